>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/c2p_pkg.sv
`default_nettype none

package c2p_pkg;

  localparam int COORD_WIDTH      = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_TAB_LEN     = 32;
  localparam int FRAC_BITS        = 16;
  localparam int MAG_W            = 16;
  localparam int ANGLE_W          = 15;
  localparam int XY_W             = COORD_WIDTH + FRAC_BITS + 3;
  localparam int Z_W              = 31;
  localparam int ATAN_W           = 28;
  localparam int ZC_W             = 29;
  localparam int FINE_W           = 31;
  localparam int GAIN_W           = 32;
  localparam int LO_W             = 20;
  localparam int HI_W             = XY_W - LO_W;
  localparam int PHI_W            = HI_W + GAIN_W;
  localparam int PLO_W            = LO_W + GAIN_W;
  localparam int SUM_W            = PHI_W + 1;
  localparam int SCALED_W         = SUM_W - 12;

  localparam logic [GAIN_W-1:0]  INV_GAIN    = 32'h9B74EDA8;
  localparam logic [ZC_W-1:0]    QUARTER_Z   = 29'd377487360;
  localparam logic [FINE_W-1:0]  HALF_FINE   = 31'd754974720;
  localparam logic [FINE_W-1:0]  FULL_FINE   = 31'd1509949440;
  localparam logic [ANGLE_W-1:0] ANG_0       = 15'd0;
  localparam logic [ANGLE_W-1:0] ANG_90      = 15'd5760;
  localparam logic [ANGLE_W-1:0] ANG_180     = 15'd11520;
  localparam logic [ANGLE_W-1:0] ANG_270     = 15'd17280;
  localparam logic [ANGLE_W:0]   FULL_TURN   = 16'd23040;

  typedef struct packed {
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
  } c2p_req_t;

  typedef struct packed {
    logic [15:0] magnitude;
    logic [14:0] angle;
  } c2p_res_t;

  typedef struct packed {
    logic               x_neg;
    logic               y_neg;
    logic               on_axis;
    logic [MAG_W-1:0]   axis_mag;
    logic [ANGLE_W-1:0] axis_ang;
  } c2p_side_t;

  function automatic logic [ATAN_W-1:0] atan_deg(input logic [4:0] idx);
    logic [ATAN_W-1:0] r;
    case (idx)
      5'd0:  r = 28'd188743680;
      5'd1:  r = 28'd111421900;
      5'd2:  r = 28'd58872272;
      5'd3:  r = 28'd29884485;
      5'd4:  r = 28'd15000234;
      5'd5:  r = 28'd7507429;
      5'd6:  r = 28'd3754631;
      5'd7:  r = 28'd1877430;
      5'd8:  r = 28'd938729;
      5'd9:  r = 28'd469366;
      5'd10: r = 28'd234683;
      5'd11: r = 28'd117342;
      5'd12: r = 28'd58671;
      5'd13: r = 28'd29335;
      5'd14: r = 28'd14668;
      5'd15: r = 28'd7334;
      5'd16: r = 28'd3667;
      5'd17: r = 28'd1833;
      5'd18: r = 28'd917;
      5'd19: r = 28'd458;
      5'd20: r = 28'd229;
      5'd21: r = 28'd115;
      5'd22: r = 28'd57;
      5'd23: r = 28'd29;
      5'd24: r = 28'd14;
      5'd25: r = 28'd7;
      5'd26: r = 28'd4;
      5'd27: r = 28'd2;
      5'd28: r = 28'd1;
      default: r = 28'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/cartesian_to_polar_degrees_unit.sv
`default_nettype none
`include "assert_macros.svh"

// Channel   Direction  Handshake              Payload
// request   in         req_valid / req_stall  req_data  (x_coord, y_coord)
// result    out        res_valid / res_stall  res_data  (magnitude, angle)
//
// One request is taken every cycle while req_stall is low; the result passes through
// one input stage, one stage per CORDIC rotation, two scaling stages and an output register.
// The pipeline depth is set by the number of rotation stages, capped at 32.
// Reset clears only the valid bits; the datapath registers are not reset.
// While a result is held under res_stall the whole pipeline freezes and req_stall is high.

module cartesian_to_polar_degrees_unit
  import c2p_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_stall,
  input  wire c2p_req_t req_data,
  output logic          res_valid,
  input  wire logic     res_stall,
  output c2p_res_t      res_data
);

  localparam int STEPS = (CORDIC_STEPS < ATAN_TAB_LEN) ? CORDIC_STEPS : ATAN_TAB_LEN;
  localparam int NVLD  = STEPS + 3;

  logic                       en;
  logic                       accept;
  logic signed [COORD_WIDTH-1:0] sx;
  logic signed [COORD_WIDTH-1:0] sy;
  logic [COORD_WIDTH-1:0]     ax;
  logic [COORD_WIDTH-1:0]     ay;
  c2p_side_t                  side_in;

  logic [NVLD-1:0]            vld;
  logic [NVLD:0]              occ;
  c2p_side_t                  side [0:STEPS+2];
  logic signed [XY_W-1:0]     cx [0:STEPS];
  logic signed [XY_W-1:0]     cy [0:STEPS-1];
  logic signed [Z_W-1:0]      z  [0:STEPS];

  logic [PHI_W-1:0]           prod_hi;
  logic [PLO_W-1:0]           prod_lo;
  logic [ZC_W-1:0]            zc;
  logic [ZC_W-1:0]            zc_next;
  logic [SCALED_W-1:0]        scaled;
  logic [SUM_W-1:0]           scaled_sum;
  logic [FINE_W-1:0]          fine;
  logic [FINE_W-1:0]          fine_next;
  logic [SCALED_W-1:0]        mag_sum;
  logic [FINE_W:0]            ang_sum;
  logic [SCALED_W-FRAC_BITS-1:0] mag_wide;
  logic [FINE_W-FRAC_BITS:0]  ang_wide;
  c2p_res_t                   res_next;

  assign en        = !(res_valid && res_stall);
  assign req_stall = !en;
  assign accept    = req_valid && en;

  assign sx = req_data.x_coord[COORD_WIDTH-1:0];
  assign sy = req_data.y_coord[COORD_WIDTH-1:0];
  assign ax = sx[COORD_WIDTH-1] ? (~sx + COORD_WIDTH'(1)) : sx;
  assign ay = sy[COORD_WIDTH-1] ? (~sy + COORD_WIDTH'(1)) : sy;

  // Points on an axis bypass the CORDIC result and carry their answer alongside.
  always_comb begin
    side_in.x_neg   = sx[COORD_WIDTH-1];
    side_in.y_neg   = sy[COORD_WIDTH-1];
    side_in.on_axis = (sy == '0) || (sx == '0);
    if (sy == '0) begin
      side_in.axis_mag = MAG_W'(ax);
      side_in.axis_ang = sx[COORD_WIDTH-1] ? ANG_180 : ANG_0;
    end else begin
      side_in.axis_mag = MAG_W'(ay);
      side_in.axis_ang = sy[COORD_WIDTH-1] ? ANG_270 : ANG_90;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[NVLD-2:0], accept};
      res_valid <= vld[NVLD-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      cx[0]   <= $signed({{(XY_W-COORD_WIDTH-FRAC_BITS){1'b0}}, ax, {FRAC_BITS{1'b0}}});
      cy[0]   <= $signed({{(XY_W-COORD_WIDTH-FRAC_BITS){1'b0}}, ay, {FRAC_BITS{1'b0}}});
      z[0]    <= '0;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_rot
    logic signed [Z_W-1:0] atan_k;
    assign atan_k = $signed({{(Z_W-ATAN_W){1'b0}}, atan_deg(5'(k))});

    always_ff @(posedge clk) begin
      if (en) begin
        side[k+1] <= side[k];
        if (!cy[k][XY_W-1]) begin
          cx[k+1] <= cx[k] + (cy[k] >>> k);
          z[k+1]  <= z[k] + atan_k;
        end else begin
          cx[k+1] <= cx[k] - (cy[k] >>> k);
          z[k+1]  <= z[k] - atan_k;
        end
      end
    end

    if (k < STEPS - 1) begin : g_cy
      always_ff @(posedge clk) begin
        if (en) begin
          if (!cy[k][XY_W-1]) begin
            cy[k+1] <= cy[k] - (cx[k] >>> k);
          end else begin
            cy[k+1] <= cy[k] + (cx[k] >>> k);
          end
        end
      end
    end
  end

  always_comb begin
    if (z[STEPS][Z_W-1]) begin
      zc_next = '0;
    end else if (ZC_W'(z[STEPS][Z_W-2:0]) > QUARTER_Z || z[STEPS][Z_W-2:ZC_W] != '0) begin
      zc_next = QUARTER_Z;
    end else begin
      zc_next = z[STEPS][ZC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[STEPS+1] <= side[STEPS];
      prod_hi       <= PHI_W'(cx[STEPS][XY_W-1:LO_W]) * PHI_W'(INV_GAIN);
      prod_lo       <= PLO_W'(cx[STEPS][LO_W-1:0]) * PLO_W'(INV_GAIN);
      zc            <= zc_next;
    end
  end

  assign scaled_sum = SUM_W'(prod_hi) + SUM_W'(prod_lo >> LO_W);

  always_comb begin
    if (!side[STEPS+1].x_neg && !side[STEPS+1].y_neg) begin
      fine_next = FINE_W'(zc);
    end else if (side[STEPS+1].x_neg && !side[STEPS+1].y_neg) begin
      fine_next = HALF_FINE - FINE_W'(zc);
    end else if (side[STEPS+1].x_neg) begin
      fine_next = HALF_FINE + FINE_W'(zc);
    end else begin
      fine_next = FULL_FINE - FINE_W'(zc);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[STEPS+2] <= side[STEPS+1];
      scaled        <= scaled_sum[SUM_W-1:12];
      fine          <= fine_next;
    end
  end

  assign mag_sum  = scaled + SCALED_W'(1 << (FRAC_BITS - 1));
  assign mag_wide = mag_sum[SCALED_W-1:FRAC_BITS];
  assign ang_sum  = {1'b0, fine} + (FINE_W+1)'(1 << (FRAC_BITS - 1));
  assign ang_wide = ang_sum[FINE_W:FRAC_BITS];

  always_comb begin
    if (side[STEPS+2].on_axis) begin
      res_next.magnitude = side[STEPS+2].axis_mag;
      res_next.angle     = side[STEPS+2].axis_ang;
    end else begin
      if (mag_wide > (SCALED_W-FRAC_BITS)'({MAG_W{1'b1}})) begin
        res_next.magnitude = '1;
      end else begin
        res_next.magnitude = mag_wide[MAG_W-1:0];
      end
      if (ang_wide[FINE_W-FRAC_BITS:0] >= (FINE_W-FRAC_BITS+1)'(FULL_TURN)) begin
        res_next.angle = ANG_0;
      end else begin
        res_next.angle = ang_wide[ANGLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_data <= res_next;
    end
  end

  assign occ = {vld, res_valid};

  `ASSERT_IMPLIES(angle_range_a, clk, rst, res_valid, (ANGLE_W+1)'(res_data.angle) < FULL_TURN, "angle out of range")
  `ASSERT_NEXT(freeze_a, clk, rst, res_valid && res_stall, $stable(occ), "pipeline moved while stalled")
  `ASSERT_ALWAYS(stall_a, clk, rst, !req_stall || res_valid, "request stalled with empty output")

endmodule

`default_nettype wire
